>>> sv/bfuh_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed constants of the universal-hash Bloom filter.
// No dependencies; used by bfuh_mul, bloom_filter_universal_hash and bfuh_check.

package bfuh_pkg;

  // Operand width of the shared multiplier. Every value that passes through it
  // (products of a coefficient and a character, running sums) stays below 2**MW.
  localparam int MW = 23;

  typedef enum logic [1:0] {
    OP_LOAD_COEF   = 2'd0,
    OP_LOAD_OFFSET = 2'd1,
    OP_INSERT      = 2'd2,
    OP_QUERY       = 2'd3
  } op_t;

  // Operand pair selected for the shared multiplier.
  typedef enum logic [2:0] {
    MS_COEF    = 3'd0,  // coefficient times character magnitude
    MS_RECIP_P = 3'd1,  // product times reciprocal of the prime
    MS_PRIME   = 3'd2,  // quotient estimate times the prime
    MS_RECIP_B = 3'd3,  // running sum times reciprocal of the table size
    MS_BITS    = 3'd4   // quotient estimate times the table size
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HRD,
    ST_HMUL,
    ST_HQUO,
    ST_HREM,
    ST_HACC,
    ST_BQUO,
    ST_BREM,
    ST_BACC,
    ST_BCHK,
    ST_DONE
  } state_t;

endpackage

>>> sv/bfuh_mul.sv
`timescale 1ns / 1ps
// Shared multiplier of the Bloom filter datapath with its operand selection.
// Depends on bfuh_pkg for the operand width and the selection codes.

module bfuh_mul #(
  parameter int PRIME = 65521,
  parameter int BITS  = 16384,
  parameter int SUMW  = 22
) (
  input  bfuh_pkg::mul_sel_t          sel,
  input  logic [15:0]                 coef,
  input  logic [7:0]                  mag,
  input  logic [bfuh_pkg::MW-1:0]     prod_lo,
  input  logic [bfuh_pkg::MW-1:0]     quot,
  input  logic [SUMW-1:0]             sum,
  output logic [2*bfuh_pkg::MW-1:0]   prod
);

  localparam int MW = bfuh_pkg::MW;
  // Reciprocals scaled by 2**MW; the estimate they give is low by at most one.
  localparam int RECIP_P = (1 << MW) / PRIME;
  localparam int RECIP_B = (1 << MW) / BITS;

  logic [MW-1:0] op_a;
  logic [MW-1:0] op_b;

  always_comb begin
    unique case (sel)
      bfuh_pkg::MS_COEF: begin
        op_a = MW'(coef);
        op_b = MW'(mag);
      end
      bfuh_pkg::MS_RECIP_P: begin
        op_a = prod_lo;
        op_b = MW'(RECIP_P);
      end
      bfuh_pkg::MS_PRIME: begin
        op_a = quot;
        op_b = MW'(PRIME);
      end
      bfuh_pkg::MS_RECIP_B: begin
        op_a = MW'(sum);
        op_b = MW'(RECIP_B);
      end
      bfuh_pkg::MS_BITS: begin
        op_a = quot;
        op_b = MW'(BITS);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = op_a * op_b;

endmodule

>>> sv/bloom_filter_universal_hash.sv
`timescale 1ns / 1ps
// Sequence: a load, or a non-final key byte past MAX_KEY, leaves busy low; any other key
// byte runs HRD, HMUL, HQUO, HREM and HACC per table with busy high. A final byte adds
// BQUO, BREM and BACC (and BCHK for a query) per table, then DONE; past MAX_KEY only DONE.
// Throughput: one transaction at a time, set by the shared multiplier; results cannot stall.
// Reset: synchronous; afterwards a clearing pass over every filter and coefficient address
// zeroes filter bits and coefficients while busy stays high.

module bloom_filter_universal_hash #(
  parameter int TABLES  = 10,
  parameter int PRIME   = 65521,
  parameter int BITS    = 16384,
  parameter int MAX_KEY = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation,
  input  logic [3:0]        table_index,
  input  logic [4:0]        char_position,
  input  logic [15:0]       load_value,
  input  logic signed [7:0] key_byte,
  input  logic              last_byte,
  output logic              done,
  output logic              was_query,
  output logic              is_member,
  output logic              key_too_long
);

  localparam int MW     = bfuh_pkg::MW;
  // Largest running sum: an offset plus MAX_KEY reduced terms, each below PRIME.
  localparam int SUMW   = $clog2(65536 + MAX_KEY * PRIME);
  localparam int TW     = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int KPW    = $clog2(MAX_KEY + 1);
  localparam int CDEPTH = TABLES * MAX_KEY;
  localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int FDEPTH = TABLES * BITS;
  localparam int FAW    = $clog2(FDEPTH);
  localparam int BW     = $clog2(BITS);
  localparam int CLRN   = (FDEPTH > CDEPTH) ? FDEPTH : CDEPTH;
  localparam int CLW    = $clog2(CLRN);

  // ---------------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------------
  bfuh_pkg::state_t state;
  bfuh_pkg::state_t state_next;

  logic [CLW-1:0]      clr_cnt;
  logic [KPW-1:0]      key_pos;     // characters hashed so far in the current key
  logic                key_ovf;     // the current key has run past MAX_KEY
  logic [TW-1:0]       tcnt;        // table being worked on
  logic [CAW-1:0]      tbase;       // tcnt * MAX_KEY, kept by repeated addition
  logic [FAW-1:0]      fbase;       // tcnt * BITS, kept by repeated addition
  bfuh_pkg::op_t       cur_op;
  logic [7:0]          mag;
  logic                cur_last;
  logic                member;

  logic [MW-1:0]       prod_lo;     // coefficient times magnitude
  logic [MW-1:0]       quot;        // quotient estimate from the reciprocal
  logic [MW-1:0]       rem;         // remainder, below twice the divisor

  logic [15:0]         offsets [TABLES];
  logic [SUMW-1:0]     sums [TABLES];

  // Memories: coefficients per table and position, and one bit per table entry.
  logic [15:0]         coef_mem [CDEPTH];
  logic                filt_mem [FDEPTH];
  logic [15:0]         coef_q;
  logic                filt_q;

  // Memory controls and multiplier selection from the output decode.
  logic                c_we;
  logic [CAW-1:0]      c_addr;
  logic [15:0]         c_wd;
  logic                f_we;
  logic [FAW-1:0]      f_addr;
  logic                f_wd;
  bfuh_pkg::mul_sel_t  mul_sel;
  logic [2*MW-1:0]     prod;

  logic                accept;
  logic                is_key_op;
  logic                coef_ok;
  logic                tab_ok;
  logic                tlast;
  logic                clr_last;
  logic                room;
  logic [SUMW-1:0]     base;
  logic [MW-1:0]       rem_p;
  logic [MW-1:0]       rem_b;
  logic [CAW-1:0]      load_addr;
  logic [FAW-1:0]      hash_addr;

  assign accept    = start && (state == bfuh_pkg::ST_IDLE);
  assign is_key_op = (operation == bfuh_pkg::OP_INSERT) || (operation == bfuh_pkg::OP_QUERY);
  // Loads aimed past the configured tables or positions are dropped.
  assign tab_ok    = 5'(table_index) < 5'(TABLES);
  assign coef_ok   = tab_ok && (7'(char_position) < 7'(MAX_KEY));
  assign load_addr = CAW'(table_index) * CAW'(MAX_KEY) + CAW'(char_position);
  assign tlast     = tcnt == TW'(TABLES - 1);
  assign clr_last  = clr_cnt == CLW'(CLRN - 1);
  assign room      = key_pos < KPW'(MAX_KEY);

  // The first character of a key starts from the table's offset.
  assign base = (key_pos == '0) ? SUMW'(offsets[tcnt]) : sums[tcnt];

  // Final correction after the reciprocal estimate: one compare and subtract.
  assign rem_p = (rem >= MW'(PRIME)) ? rem - MW'(PRIME) : rem;
  assign rem_b = (rem >= MW'(BITS)) ? rem - MW'(BITS) : rem;
  assign hash_addr = fbase + FAW'(BW'(rem_b));

  bfuh_mul #(
    .PRIME (PRIME),
    .BITS  (BITS),
    .SUMW  (SUMW)
  ) u_mul (
    .sel     (mul_sel),
    .coef    (coef_q),
    .mag     (mag),
    .prod_lo (prod_lo),
    .quot    (quot),
    .sum     (sums[tcnt]),
    .prod    (prod)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      bfuh_pkg::ST_CLEAR: begin
        if (clr_last) state_next = bfuh_pkg::ST_IDLE;
      end
      bfuh_pkg::ST_IDLE: begin
        if (accept && is_key_op) begin
          if (room) state_next = bfuh_pkg::ST_HRD;
          else if (last_byte) state_next = bfuh_pkg::ST_DONE;
        end
      end
      bfuh_pkg::ST_HRD:  state_next = bfuh_pkg::ST_HMUL;
      bfuh_pkg::ST_HMUL: state_next = bfuh_pkg::ST_HQUO;
      bfuh_pkg::ST_HQUO: state_next = bfuh_pkg::ST_HREM;
      bfuh_pkg::ST_HREM: state_next = bfuh_pkg::ST_HACC;
      bfuh_pkg::ST_HACC: begin
        if (!tlast) state_next = bfuh_pkg::ST_HRD;
        else if (cur_last) state_next = bfuh_pkg::ST_BQUO;
        else state_next = bfuh_pkg::ST_IDLE;
      end
      bfuh_pkg::ST_BQUO: state_next = bfuh_pkg::ST_BREM;
      bfuh_pkg::ST_BREM: state_next = bfuh_pkg::ST_BACC;
      bfuh_pkg::ST_BACC: begin
        if (cur_op == bfuh_pkg::OP_QUERY) state_next = bfuh_pkg::ST_BCHK;
        else if (tlast) state_next = bfuh_pkg::ST_DONE;
        else state_next = bfuh_pkg::ST_BQUO;
      end
      bfuh_pkg::ST_BCHK: begin
        state_next = tlast ? bfuh_pkg::ST_DONE : bfuh_pkg::ST_BQUO;
      end
      bfuh_pkg::ST_DONE: state_next = bfuh_pkg::ST_IDLE;
      default: state_next = bfuh_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output decode: handshake, multiplier operands and memory ports
  // ---------------------------------------------------------------------------
  always_comb begin
    busy    = state != bfuh_pkg::ST_IDLE;
    done    = state == bfuh_pkg::ST_DONE;
    mul_sel = bfuh_pkg::MS_COEF;
    c_we    = 1'b0;
    c_addr  = tbase + CAW'(key_pos);
    c_wd    = load_value;
    f_we    = 1'b0;
    f_addr  = hash_addr;
    f_wd    = 1'b1;
    unique case (state)
      bfuh_pkg::ST_CLEAR: begin
        c_we   = (CLW + 1)'(clr_cnt) < (CLW + 1)'(CDEPTH);
        c_addr = CAW'(clr_cnt);
        c_wd   = '0;
        f_we   = (CLW + 1)'(clr_cnt) < (CLW + 1)'(FDEPTH);
        f_addr = FAW'(clr_cnt);
        f_wd   = 1'b0;
      end
      bfuh_pkg::ST_IDLE: begin
        c_we   = accept && (operation == bfuh_pkg::OP_LOAD_COEF) && coef_ok;
        c_addr = load_addr;
      end
      bfuh_pkg::ST_HMUL: mul_sel = bfuh_pkg::MS_COEF;
      bfuh_pkg::ST_HQUO: mul_sel = bfuh_pkg::MS_RECIP_P;
      bfuh_pkg::ST_HREM: mul_sel = bfuh_pkg::MS_PRIME;
      bfuh_pkg::ST_BQUO: mul_sel = bfuh_pkg::MS_RECIP_B;
      bfuh_pkg::ST_BREM: mul_sel = bfuh_pkg::MS_BITS;
      bfuh_pkg::ST_BACC: begin
        // Inserts set the bit; queries read it and check it in the next cycle.
        f_we = cur_op != bfuh_pkg::OP_QUERY;
      end
      bfuh_pkg::ST_HRD, bfuh_pkg::ST_HACC, bfuh_pkg::ST_BCHK, bfuh_pkg::ST_DONE: begin
        mul_sel = bfuh_pkg::MS_COEF;
      end
      default: mul_sel = bfuh_pkg::MS_COEF;
    endcase
  end

  // Result fields are held in registers and marked valid by done.
  assign was_query    = cur_op == bfuh_pkg::OP_QUERY;
  assign key_too_long = key_ovf;
  assign is_member    = was_query && !key_ovf && member;

  // ---------------------------------------------------------------------------
  // Memories: one port each, registered read data.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (c_we) coef_mem[c_addr] <= c_wd;
    coef_q <= coef_mem[c_addr];
  end

  always_ff @(posedge clk) begin
    if (f_we) filt_mem[f_addr] <= f_wd;
    filt_q <= filt_mem[f_addr];
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bfuh_pkg::ST_CLEAR;
      clr_cnt <= '0;
      key_pos <= '0;
      key_ovf <= 1'b0;
      tcnt    <= '0;
      tbase   <= '0;
      fbase   <= '0;
      cur_op  <= bfuh_pkg::OP_INSERT;
      for (int i = 0; i < TABLES; i++) offsets[i] <= '0;
    end else begin
      state <= state_next;
      if (state == bfuh_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;

      if (accept && (operation == bfuh_pkg::OP_LOAD_OFFSET) && tab_ok) begin
        offsets[table_index[TW-1:0]] <= load_value;
      end

      if (accept && is_key_op) begin
        cur_op <= bfuh_pkg::op_t'(operation);
        tcnt   <= '0;
        tbase  <= '0;
        // Characters past MAX_KEY are not hashed; they only mark the key.
        if (!room) key_ovf <= 1'b1;
      end

      if (state == bfuh_pkg::ST_HACC) begin
        if (tlast) begin
          key_pos <= key_pos + 1'b1;
          tcnt    <= '0;
          fbase   <= '0;
        end else begin
          tcnt  <= tcnt + 1'b1;
          tbase <= tbase + CAW'(MAX_KEY);
        end
      end

      if (((state == bfuh_pkg::ST_BACC) && (cur_op != bfuh_pkg::OP_QUERY)) ||
          (state == bfuh_pkg::ST_BCHK)) begin
        tcnt  <= tcnt + 1'b1;
        fbase <= fbase + FAW'(BITS);
      end

      // The key ends with its result: start the next one from scratch.
      if (state == bfuh_pkg::ST_DONE) begin
        key_pos <= '0;
        key_ovf <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers of the shared arithmetic
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept && is_key_op) begin
      mag      <= key_byte[7] ? 8'(-key_byte) : 8'(key_byte);
      cur_last <= last_byte;
    end
    unique case (state)
      bfuh_pkg::ST_HMUL: prod_lo <= prod[MW-1:0];
      bfuh_pkg::ST_HQUO: quot    <= prod[2*MW-1:MW];
      bfuh_pkg::ST_HREM: rem     <= prod_lo - prod[MW-1:0];
      bfuh_pkg::ST_HACC: begin
        sums[tcnt] <= base + SUMW'(rem_p);
        member     <= 1'b1;
      end
      bfuh_pkg::ST_BQUO: quot    <= prod[2*MW-1:MW];
      bfuh_pkg::ST_BREM: rem     <= MW'(sums[tcnt]) - prod[MW-1:0];
      bfuh_pkg::ST_BCHK: member  <= member & filt_q;
      bfuh_pkg::ST_CLEAR, bfuh_pkg::ST_IDLE, bfuh_pkg::ST_HRD, bfuh_pkg::ST_BACC,
      bfuh_pkg::ST_DONE: begin
        member <= member;
      end
      default: member <= member;
    endcase
  end

endmodule

>>> sv/bfuh_check.sv
`timescale 1ns / 1ps
// Port-level checks of the Bloom filter top level, attached by a bind statement.
// Depends on bfuh_pkg for operation codes and on bloom_filter_universal_hash.

module bfuh_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] operation,
  input logic       last_byte,
  input logic       done,
  input logic       was_query,
  input logic       is_member,
  input logic       key_too_long
);

  // A result is never held over: every transaction yields at most one.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  // Results come out while the block is busy with the finishing transaction.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

  // Membership is reported only for a query whose key was applied.
  a_member_query: assert property (@(posedge clk) disable iff (rst)
      done && is_member |-> was_query && !key_too_long)
    else $error("membership reported for an insert or an overlong key");

  // A final key byte always keeps the block busy until its result.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
      start && !busy && last_byte &&
      (operation == bfuh_pkg::OP_INSERT || operation == bfuh_pkg::OP_QUERY) |=> busy)
    else $error("final key byte accepted without becoming busy");

endmodule

bind bloom_filter_universal_hash bfuh_check u_bfuh_check (.*);

>>> tb/bloom_filter_universal_hash_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bloom_filter_universal_hash: directed table, then random keys.
// Depends on bfuh_pkg (operation codes) and the bloom_filter_universal_hash RTL.

module bloom_filter_universal_hash_tb;
  import bfuh_pkg::*;

  localparam int TABLES  = 10;
  localparam int PRIME   = 65521;
  localparam int BITS    = 16384;
  localparam int MAX_KEY = 32;

  // The clearing pass after reset runs with no transaction at all.
  // Any other quiet stretch is one key byte plus a sender gap.
  // The limit covers the clearing pass with room to spare.
  localparam int WATCHDOG_LIMIT = 3 * (TABLES * BITS + 200);
  // Cycles allowed after the last result so that a stray result still shows up.
  localparam int TAIL_CYCLES    = 200;
  localparam int RANDOM_BYTES   = 440;
  localparam int DIRECTED_ROWS  = 29;
  localparam int SAVED_KEYS     = 16;

  typedef struct packed {
    logic was_query;
    logic is_member;
    logic key_too_long;
  } filter_result_t;

  typedef struct {
    op_t                op;
    logic [3:0]         tbl;
    logic [4:0]         pos;
    logic [15:0]        val;
    logic signed [7:0]  kb;
    logic               last;
  } filter_cmd_t;

  // One row of the directed table. A row is repeated reps times; only the final copy
  // carries the row's last flag. Where typed is set, the result written in the row is the
  // expectation; otherwise the predictor supplies it.
  typedef struct {
    op_t                op;
    logic [3:0]         tbl;
    logic [4:0]         pos;
    logic [15:0]        val;
    logic signed [7:0]  kb;
    logic               last;
    int                 reps;
    bit                 typed;
    filter_result_t     res;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        operation = 2'd0;
  logic [3:0]        table_index = 4'd0;
  logic [4:0]        char_position = 5'd0;
  logic [15:0]       load_value = 16'd0;
  logic signed [7:0] key_byte = 8'sd0;
  logic              last_byte = 1'b0;
  logic              done;
  logic              was_query;
  logic              is_member;
  logic              key_too_long;

  bloom_filter_universal_hash #(
    .TABLES(TABLES),
    .PRIME(PRIME),
    .BITS(BITS),
    .MAX_KEY(MAX_KEY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .table_index(table_index),
    .char_position(char_position),
    .load_value(load_value),
    .key_byte(key_byte),
    .last_byte(last_byte),
    .done(done),
    .was_query(was_query),
    .is_member(is_member),
    .key_too_long(key_too_long)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Filter model. The bit arrays start cleared, which matches the state after the
  // clearing pass. Every hashed character adds (coefficient * |c|) mod PRIME to the
  // running sum of each table; the sum starts from the table's offset.
  // ---------------------------------------------------------------------------
  bit [15:0]   coef_model   [TABLES][MAX_KEY];
  bit [15:0]   offset_model [TABLES];
  int unsigned sum_model    [TABLES];
  int unsigned key_len_model;
  bit          overflow_model;
  bit          filter_model [TABLES * BITS];

  filter_result_t pending_results[$];
  int             error_count = 0;
  int             stall_cycles = 0;
  bit             no_idle = 1'b0;

  logic signed [7:0] saved_key [SAVED_KEYS][MAX_KEY];
  int                saved_len [SAVED_KEYS];
  int                saved_count = 0;
  int                saved_next = 0;
  int                random_bytes = 0;

  // Applies one transaction to the model; returns 1 when it finishes a key.
  function automatic bit predict_filter_step(input filter_cmd_t c, output filter_result_t r);
    int unsigned mag;
    int unsigned base;
    int unsigned addr;
    bit          query;
    bit          member;
    r = '0;
    case (c.op)
      OP_LOAD_COEF: begin
        // Loads to tables that do not exist are dropped. Every 5-bit position exists.
        if (c.tbl < TABLES && c.pos < MAX_KEY) coef_model[c.tbl][c.pos] = c.val;
        return 1'b0;
      end
      OP_LOAD_OFFSET: begin
        if (c.tbl < TABLES) offset_model[c.tbl] = c.val;
        return 1'b0;
      end
      default: begin
        // Magnitude taken in int so that -128 gives 128.
        mag = (c.kb < 0) ? -int'(c.kb) : int'(c.kb);
        if (key_len_model < MAX_KEY) begin
          for (int t = 0; t < TABLES; t++) begin
            base = (key_len_model == 0) ? offset_model[t] : sum_model[t];
            sum_model[t] = base + (coef_model[t][key_len_model] * mag) % PRIME;
          end
          key_len_model++;
        end else begin
          overflow_model = 1'b1;
        end
        if (!c.last) return 1'b0;
        // The operation of the final byte alone decides insert versus query.
        query  = (c.op == OP_QUERY);
        member = 1'b1;
        if (!overflow_model) begin
          for (int t = 0; t < TABLES; t++) begin
            addr = t * BITS + sum_model[t] % BITS;
            if (query) member &= filter_model[addr];
            else filter_model[addr] = 1'b1;
          end
        end
        r.was_query    = query;
        r.is_member    = query && !overflow_model && member;
        r.key_too_long = overflow_model;
        key_len_model  = 0;
        overflow_model = 1'b0;
        for (int t = 0; t < TABLES; t++) sum_model[t] = 0;
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Inputs change only at rising edges with nonblocking assignments.
  // start is raised once per transaction and lowered only when a gap follows, so it
  // never gets two assignments in the same time step.
  // ---------------------------------------------------------------------------
  task automatic issue_transaction(input filter_cmd_t c, input bit typed,
                                   input filter_result_t typed_res);
    filter_result_t r;
    bit             has_result;
    start         <= 1'b1;
    operation     <= c.op;
    table_index   <= c.tbl;
    char_position <= c.pos;
    load_value    <= c.val;
    key_byte      <= c.kb;
    last_byte     <= c.last;
    // The transaction goes through at the first edge that sees busy low.
    do @(posedge clk); while (busy !== 1'b0);
    has_result = predict_filter_step(c, r);
    if (has_result) pending_results.push_back(typed ? typed_res : r);
  endtask

  // Random gap before the next transaction: mostly short, now and then longer than
  // a whole final-byte computation so that gaps land on every phase.
  task automatic sender_pause();
    if (!no_idle && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 6))
        @(posedge clk);
    end
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic wait_results_drained();
    start <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  // A random load. Noise loads may address missing tables and use any 16-bit value.
  function automatic filter_cmd_t random_load(input bit noise);
    filter_cmd_t c;
    c.op   = ($urandom_range(0, 1) == 0) ? OP_LOAD_COEF : OP_LOAD_OFFSET;
    c.tbl  = noise ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, TABLES - 1));
    c.pos  = 5'($urandom_range(0, 31));
    if (noise) c.val = 16'($urandom);
    else if ($urandom_range(0, 15) == 0) c.val = 16'($urandom_range(PRIME, 65535));
    else c.val = 16'($urandom_range(0, PRIME - 1));
    c.kb   = 8'($urandom);
    c.last = 1'($urandom);
    return c;
  endfunction

  // Sends one key byte by byte. Earlier bytes may carry either key operation, and loads
  // are sometimes slipped in between bytes; both must leave the key intact.
  task automatic send_key(input int len, input op_t final_op, input int slot);
    logic signed [7:0] key_buf [MAX_KEY + 8];
    filter_cmd_t       c;
    for (int i = 0; i < len; i++)
      key_buf[i] = (slot >= 0) ? saved_key[slot][i] : 8'($urandom);
    if (slot < 0 && final_op == OP_INSERT && len <= MAX_KEY) begin
      for (int i = 0; i < len; i++) saved_key[saved_next][i] = key_buf[i];
      saved_len[saved_next] = len;
      saved_next = (saved_next + 1) % SAVED_KEYS;
      if (saved_count < SAVED_KEYS) saved_count++;
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        sender_pause();
        issue_transaction(random_load(1'b0), 1'b0, '0);
      end
      c.tbl  = 4'($urandom);
      c.pos  = 5'($urandom);
      c.val  = 16'($urandom);
      c.kb   = key_buf[i];
      c.last = (i == len - 1);
      if (i == len - 1 || $urandom_range(0, 3) != 0) c.op = final_op;
      else c.op = (final_op == OP_INSERT) ? OP_QUERY : OP_INSERT;
      sender_pause();
      issue_transaction(c, 1'b0, '0);
      random_bytes++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking. The strobe lasts one cycle and is sampled at the edge that ends it.
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string what, input filter_result_t exp_r,
                            input filter_result_t got_r);
    if (error_count < 10)
      $display("%0t: %s: expected was_query=%0b is_member=%0b key_too_long=%0b, got %0b %0b %0b",
               $realtime, what, exp_r.was_query, exp_r.is_member, exp_r.key_too_long,
               got_r.was_query, got_r.is_member, got_r.key_too_long);
    error_count++;
  endtask

  always @(posedge clk) begin
    filter_result_t got_r;
    filter_result_t exp_r;
    if (!rst && done === 1'b1) begin
      got_r = '{was_query, is_member, key_too_long};
      if (pending_results.size() == 0) begin
        flag_error("result with no transaction waiting", '0, got_r);
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r.was_query !== exp_r.was_query || got_r.is_member !== exp_r.is_member ||
            got_r.key_too_long !== exp_r.key_too_long)
          flag_error("result mismatch", exp_r, got_r);
      end
    end
  end

  // Watchdog: counts cycles in which neither side completes a transaction.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("bloom_filter_universal_hash verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  directed_row_t directed_rows [DIRECTED_ROWS];

  initial begin
    filter_cmd_t c;
    int          pick;
    int          next_drain;
    directed_rows = '{
      // With all coefficients and offsets zero every key hashes to bit 0 of each table,
      // so the first query misses, and after one insert any key is a member.
      '{OP_QUERY,       4'd0,  5'd0,  16'd0,     8'sd5,   1'b1, 1,  1'b1, '{1'b1, 1'b0, 1'b0}},
      '{OP_INSERT,      4'd0,  5'd0,  16'd0,     8'h80,   1'b1, 1,  1'b1, '{1'b0, 1'b0, 1'b0}},
      '{OP_QUERY,       4'd0,  5'd0,  16'd0,     8'sd127, 1'b1, 1,  1'b1, '{1'b1, 1'b1, 1'b0}},
      // Loads to missing tables, values just below and above the prime, loads marked last.
      '{OP_LOAD_OFFSET, 4'd15, 5'd0,  16'hFFFF,  8'sd0,   1'b1, 1,  1'b0, '0},
      '{OP_LOAD_COEF,   4'd10, 5'd31, 16'hFFFF,  8'hFF,   1'b1, 1,  1'b0, '0},
      '{OP_LOAD_COEF,   4'd0,  5'd31, 16'hFFFF,  8'sd0,   1'b0, 1,  1'b0, '0},
      '{OP_LOAD_COEF,   4'd9,  5'd0,  16'd65520, 8'sd0,   1'b0, 1,  1'b0, '0},
      '{OP_LOAD_OFFSET, 4'd9,  5'd0,  16'hFFFF,  8'sd0,   1'b1, 1,  1'b0, '0},
      '{OP_LOAD_OFFSET, 4'd3,  5'd0,  16'd16383, 8'sd0,   1'b0, 1,  1'b0, '0},
      '{OP_LOAD_COEF,   4'd5,  5'd1,  16'hAAAA,  8'sd0,   1'b0, 1,  1'b0, '0},
      '{OP_LOAD_COEF,   4'd6,  5'd2,  16'h5555,  8'sd0,   1'b0, 1,  1'b0, '0},
      // A three-character key with a zero character, inserted and then queried.
      '{OP_INSERT,      4'd0,  5'd0,  16'd0,     8'sd0,   1'b0, 1,  1'b0, '0},
      '{OP_INSERT,      4'd0,  5'd0,  16'd0,     8'hFF,   1'b0, 1,  1'b0, '0},
      '{OP_INSERT,      4'd0,  5'd0,  16'd0,     8'sd127, 1'b1, 1,  1'b1, '{1'b0, 1'b0, 1'b0}},
      '{OP_QUERY,       4'd0,  5'd0,  16'd0,     8'sd0,   1'b0, 1,  1'b0, '0},
      '{OP_QUERY,       4'd0,  5'd0,  16'd0,     8'hFF,   1'b0, 1,  1'b0, '0},
      '{OP_QUERY,       4'd0,  5'd0,  16'd0,     8'sd127, 1'b1, 1,  1'b0, '0},
      // Mixed operations within one key; the final byte makes it a query.
      '{OP_QUERY,       4'd0,  5'd0,  16'd0,     8'sd7,   1'b0, 1,  1'b0, '0},
      '{OP_INSERT,      4'd0,  5'd0,  16'd0,     8'hF9,   1'b0, 1,  1'b0, '0},
      '{OP_QUERY,       4'd0,  5'd0,  16'd0,     8'sd100, 1'b1, 1,  1'b0, '0},
      // A coefficient load in the middle of a key takes effect at once.
      '{OP_INSERT,      4'd0,  5'd0,  16'd0,     8'sd1,   1'b0, 1,  1'b0, '0},
      '{OP_LOAD_COEF,   4'd1,  5'd1,  16'd12345, 8'sd0,   1'b1, 1,  1'b0, '0},
      '{OP_INSERT,      4'd0,  5'd0,  16'd0,     8'sd2,   1'b1, 1,  1'b1, '{1'b0, 1'b0, 1'b0}},
      // Keys longer than MAX_KEY are flagged and leave the filter alone.
      '{OP_INSERT,      4'd0,  5'd0,  16'd0,     8'h55,   1'b1, 33, 1'b1, '{1'b0, 1'b0, 1'b1}},
      '{OP_QUERY,       4'd0,  5'd0,  16'd0,     8'h80,   1'b1, 40, 1'b1, '{1'b1, 1'b0, 1'b1}},
      // Exactly MAX_KEY characters is still a normal key.
      '{OP_QUERY,       4'd0,  5'd0,  16'd0,     8'h33,   1'b1, 32, 1'b0, '0},
      '{OP_LOAD_COEF,   4'd0,  5'd0,  16'd1000,  8'sd0,   1'b0, 1,  1'b0, '0},
      '{OP_INSERT,      4'd0,  5'd0,  16'd0,     8'h80,   1'b1, 1,  1'b1, '{1'b0, 1'b0, 1'b0}},
      '{OP_QUERY,       4'd0,  5'd0,  16'd0,     8'h80,   1'b1, 1,  1'b0, '0}
    };

    // Reset is held at the start; the block then runs its clearing pass with busy
    // high, which the first transaction simply waits out.
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      for (int k = 0; k < directed_rows[i].reps; k++) begin
        c.op   = directed_rows[i].op;
        c.tbl  = directed_rows[i].tbl;
        c.pos  = directed_rows[i].pos;
        c.val  = directed_rows[i].val;
        c.kb   = directed_rows[i].kb;
        c.last = (k == directed_rows[i].reps - 1) ? directed_rows[i].last : 1'b0;
        sender_pause();
        issue_transaction(c, directed_rows[i].typed, directed_rows[i].res);
      end
      if (i == 2) wait_results_drained();
    end
    wait_results_drained();

    // Give the hash a spread: every offset and the coefficients of the first eight
    // positions get values, so that short random keys land on different bits.
    for (int t = 0; t < TABLES; t++) begin
      c = random_load(1'b0);
      c.op  = OP_LOAD_OFFSET;
      c.tbl = 4'(t);
      sender_pause();
      issue_transaction(c, 1'b0, '0);
      for (int p = 0; p < 8; p++) begin
        c = random_load(1'b0);
        c.op  = OP_LOAD_COEF;
        c.tbl = 4'(t);
        c.pos = 5'(p);
        sender_pause();
        issue_transaction(c, 1'b0, '0);
      end
    end

    // Random keys: mostly short well-formed keys, some queries of keys inserted earlier
    // so that hits occur, a few overlong keys, and stray loads as noise.
    next_drain = 150;
    while (random_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        sender_pause();
        issue_transaction(random_load(1'b1), 1'b0, '0);
      end else if (pick < 11) begin
        send_key($urandom_range(MAX_KEY + 1, MAX_KEY + 8),
                 ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_QUERY, -1);
      end else if (pick < 30 && saved_count > 0) begin
        pick = $urandom_range(0, saved_count - 1);
        send_key(saved_len[pick], OP_QUERY, pick);
      end else begin
        send_key(($urandom_range(0, 9) == 0) ? $urandom_range(7, MAX_KEY) : $urandom_range(1, 6),
                 ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_QUERY, -1);
      end
      if (random_bytes >= next_drain) begin
        wait_results_drained();
        next_drain += 150;
      end
      // A stretch of back-to-back transactions with no sender gaps.
      no_idle = (random_bytes >= 250 && random_bytes < 400);
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("bloom_filter_universal_hash verification clean");
    end else begin
      $display("bloom_filter_universal_hash verification failed");
    end
    $finish;
  end

endmodule
